[sv/ddo_pkg.sv]
`default_nettype none

package ddo_pkg;

    // Field widths of the two channels.
    localparam int SPEED_W    = 11;
    localparam int POS_W      = 32;
    localparam int ANGLE_BITS = 16;

    // Position fraction bits (metres times 2^POSITION_FRAC_BITS).
    localparam int POSITION_FRAC_BITS = 20;

    // Forward step du, signed, in position units.
    localparam int DU_W  = POSITION_FRAC_BITS;
    localparam int DU_SH = 44 - POSITION_FRAC_BITS;

    // Heading step rounding.
    localparam int DTH_SH = 44 - ANGLE_BITS;

    // CORDIC: 32-bit binary angle, Q30 sine and cosine, 33-bit signed registers.
    localparam int ANG_FULL       = 32;
    localparam int CORDIC_W       = 33;
    localparam int CORDIC_STEPS   = 28;
    localparam int ITER_W         = $clog2(CORDIC_STEPS);
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [29:0] ATAN_TURN32 [0:CORDIC_STEPS-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5
    };

    // Scale constants, worked out at elaboration.
    // KDU48: half the travel per speed unit in Q48 metres.
    // TURN44: heading change per unit of speed difference, in Q44 turns.
    localparam logic [63:0] KDU48  = ((64'd32185 << 43) + 64'd122070312) / 64'd244140625;
    localparam logic [63:0] RAD40  = ((64'd32185 << 37) + 64'd12695312) / 64'd25390625;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TURN44 = ((RAD40 << 33) + (PI_Q30 / 64'd2)) / PI_Q30;

    // Shared multiplier operand and product widths.
    localparam int MA_W = (DU_W > SPEED_W + 1) ? DU_W : SPEED_W + 1;
    localparam int MB_W = CORDIC_W;
    localparam int P_W  = MA_W + MB_W;

    localparam logic signed [MB_W-1:0] KDU_B  = MB_W'(KDU48);
    localparam logic signed [MB_W-1:0] TURN_B = MB_W'(TURN44);

    // Rounding offsets (half of the dropped weight).
    localparam int XZ_SH = 34;
    localparam logic signed [P_W-1:0] RND_DU  = P_W'(1) << (DU_SH - 1);
    localparam logic signed [P_W-1:0] RND_DTH = P_W'(1) << (DTH_SH - 1);
    localparam logic signed [P_W-1:0] RND_XZ  = P_W'(1) << (XZ_SH - 1);

    // Multiplier operand select codes.
    localparam int MUL_SEL_W = 2;
    localparam logic [MUL_SEL_W-1:0] MUL_DU  = 2'd0;
    localparam logic [MUL_SEL_W-1:0] MUL_DTH = 2'd1;
    localparam logic [MUL_SEL_W-1:0] MUL_X   = 2'd2;
    localparam logic [MUL_SEL_W-1:0] MUL_Z   = 2'd3;

    typedef struct packed {
        logic                 load;
        logic                 mul_en;
        logic [MUL_SEL_W-1:0] mul_sel;
        logic                 du_load;
        logic                 dth_load;
        logic                 cordic_init;
        logic                 cordic_step;
        logic                 upd_x;
        logic                 upd_z;
        logic                 out_load;
    } ddo_cmd_t;

    typedef struct packed {
        logic cordic_last;
    } ddo_sts_t;

endpackage

`default_nettype wire

[sv/ddo_if.sv]
`default_nettype none

interface ddo_in_if;
    import ddo_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      restart_pose;

    modport source (output valid, output left_speed, output right_speed,
                    output restart_pose, input ready);
    modport sink   (input valid, input left_speed, input right_speed,
                    input restart_pose, output ready);
endinterface

interface ddo_out_if;
    import ddo_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_z;
    logic [ANGLE_BITS-1:0]   pose_heading;

    modport source (output valid, output pose_x, output pose_z,
                    output pose_heading, input ready);
    modport sink   (input valid, input pose_x, input pose_z,
                    input pose_heading, output ready);
endinterface

`default_nettype wire

[sv/ddo_datapath.sv]
`default_nettype none

module ddo_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ddo_pkg::ddo_cmd_t                  cmd,
    output ddo_pkg::ddo_sts_t                  sts,
    input  logic signed [ddo_pkg::SPEED_W-1:0] left_speed,
    input  logic signed [ddo_pkg::SPEED_W-1:0] right_speed,
    input  logic                               restart_pose,
    output logic signed [ddo_pkg::POS_W-1:0]   pose_x,
    output logic signed [ddo_pkg::POS_W-1:0]   pose_z,
    output logic [ddo_pkg::ANGLE_BITS-1:0]     pose_heading
);
    import ddo_pkg::*;

    // Captured speeds.
    logic signed [SPEED_W-1:0]  left_reg, left_next;
    logic signed [SPEED_W-1:0]  right_reg, right_next;

    // Step terms and shared multiplier.
    logic signed [DU_W-1:0]     du_reg, du_next;
    logic [ANGLE_BITS-1:0]      dth_reg, dth_next;
    logic signed [P_W-1:0]      prod_reg, prod_next;

    // CORDIC rotator.
    logic signed [CORDIC_W-1:0] cx_reg, cx_next;
    logic signed [CORDIC_W-1:0] cy_reg, cy_next;
    logic signed [CORDIC_W-1:0] cz_reg, cz_next;
    logic                       flip_reg, flip_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;

    // Pose state and result register.
    logic signed [POS_W-1:0]    pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]    pos_z_reg, pos_z_next;
    logic [ANGLE_BITS-1:0]      heading_reg, heading_next;
    logic signed [POS_W-1:0]    out_x_reg, out_x_next;
    logic signed [POS_W-1:0]    out_z_reg, out_z_next;
    logic [ANGLE_BITS-1:0]      out_h_reg, out_h_next;

    logic signed [SPEED_W:0]    sum_lr;
    logic signed [SPEED_W:0]    diff_lr;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [P_W-1:0]      mul_p;
    logic signed [CORDIC_W-1:0] sin_q30;
    logic signed [CORDIC_W-1:0] cos_q30;

    logic signed [P_W-1:0]      du_sum, du_shift;
    logic signed [P_W-1:0]      dth_sum, dth_shift;
    logic signed [P_W-1:0]      xz_sum, xz_shift;
    logic signed [POS_W+1:0]    xz_step;
    logic signed [POS_W+1:0]    pos_src;
    logic signed [POS_W+1:0]    pos_new;
    logic signed [POS_W-1:0]    pos_sat;

    logic [ANG_FULL-1:0]        ang_init;
    logic                       flip_init;
    logic signed [CORDIC_W-1:0] z_init;
    logic signed [CORDIC_W-1:0] xs, ys, atan_ext;
    logic                       restart_now;

    assign sum_lr  = {left_reg[SPEED_W-1], left_reg} + {right_reg[SPEED_W-1], right_reg};
    assign diff_lr = {right_reg[SPEED_W-1], right_reg} - {left_reg[SPEED_W-1], left_reg};

    assign sin_q30 = flip_reg ? -cy_reg : cy_reg;
    assign cos_q30 = flip_reg ? -cx_reg : cx_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_DU:
            begin
                mul_a = MA_W'(sum_lr);
                mul_b = KDU_B;
            end
            MUL_DTH:
            begin
                mul_a = MA_W'(diff_lr);
                mul_b = TURN_B;
            end
            MUL_X:
            begin
                mul_a = MA_W'(du_reg);
                mul_b = sin_q30;
            end
            MUL_Z:
            begin
                mul_a = MA_W'(du_reg);
                mul_b = cos_q30;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round half up, then drop the fraction.
    assign du_sum    = prod_reg + RND_DU;
    assign du_shift  = du_sum >>> DU_SH;
    assign dth_sum   = prod_reg + RND_DTH;
    assign dth_shift = dth_sum >>> DTH_SH;
    assign xz_sum    = prod_reg + RND_XZ;
    assign xz_shift  = xz_sum >>> XZ_SH;
    assign xz_step   = xz_shift[POS_W+1:0];

    // The position moves against the rotated forward step; saturate to 32 bits.
    assign pos_src = cmd.upd_x ? {{2{pos_x_reg[POS_W-1]}}, pos_x_reg}
                               : {{2{pos_z_reg[POS_W-1]}}, pos_z_reg};
    assign pos_new = pos_src - xz_step;

    always_comb
    begin
        if ((pos_new[POS_W+1] == pos_new[POS_W]) && (pos_new[POS_W] == pos_new[POS_W-1]))
        begin
            pos_sat = pos_new[POS_W-1:0];
        end
        else if (pos_new[POS_W+1])
        begin
            pos_sat = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            pos_sat = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    // Angles in the left half-plane are turned by half a turn and the results negated.
    assign ang_init  = {heading_reg, (ANG_FULL-ANGLE_BITS)'(0)};
    assign flip_init = ang_init[ANG_FULL-1] ^ ang_init[ANG_FULL-2];
    assign z_init    = CORDIC_W'($signed({ang_init[ANG_FULL-1] ^ flip_init,
                                          ang_init[ANG_FULL-2:0]}));

    assign xs       = cx_reg >>> iter_reg;
    assign ys       = cy_reg >>> iter_reg;
    assign atan_ext = CORDIC_W'(ATAN_TURN32[iter_reg]);

    assign sts.cordic_last = (iter_reg == ITER_W'(CORDIC_STEPS - 1));
    assign restart_now     = cmd.load && restart_pose;

    always_comb
    begin
        left_next    = cmd.load ? left_speed : left_reg;
        right_next   = cmd.load ? right_speed : right_reg;
        prod_next    = cmd.mul_en ? mul_p : prod_reg;
        du_next      = cmd.du_load ? du_shift[DU_W-1:0] : du_reg;
        dth_next     = cmd.dth_load ? dth_shift[ANGLE_BITS-1:0] : dth_reg;

        cx_next   = cx_reg;
        cy_next   = cy_reg;
        cz_next   = cz_reg;
        flip_next = flip_reg;
        iter_next = iter_reg;
        if (cmd.cordic_init)
        begin
            cx_next   = CORDIC_GAIN;
            cy_next   = '0;
            cz_next   = z_init;
            flip_next = flip_init;
            iter_next = '0;
        end
        else if (cmd.cordic_step)
        begin
            if (!cz_reg[CORDIC_W-1])
            begin
                cx_next = cx_reg - ys;
                cy_next = cy_reg + xs;
                cz_next = cz_reg - atan_ext;
            end
            else
            begin
                cx_next = cx_reg + ys;
                cy_next = cy_reg - xs;
                cz_next = cz_reg + atan_ext;
            end
            iter_next = sts.cordic_last ? '0 : iter_reg + 1'b1;
        end

        pos_x_next   = pos_x_reg;
        pos_z_next   = pos_z_reg;
        heading_next = heading_reg;
        if (restart_now)
        begin
            pos_x_next   = '0;
            pos_z_next   = '0;
            heading_next = '0;
        end
        else if (cmd.upd_x)
        begin
            pos_x_next = pos_sat;
        end
        else if (cmd.upd_z)
        begin
            pos_z_next   = pos_sat;
            heading_next = heading_reg + dth_reg;
        end

        out_x_next = cmd.out_load ? pos_x_reg : out_x_reg;
        out_z_next = cmd.out_load ? pos_z_reg : out_z_reg;
        out_h_next = cmd.out_load ? heading_reg : out_h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg    <= '0;
            pos_x_reg   <= '0;
            pos_z_reg   <= '0;
            heading_reg <= '0;
        end
        else
        begin
            iter_reg    <= iter_next;
            pos_x_reg   <= pos_x_next;
            pos_z_reg   <= pos_z_next;
            heading_reg <= heading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        prod_reg  <= prod_next;
        du_reg    <= du_next;
        dth_reg   <= dth_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        flip_reg  <= flip_next;
        out_x_reg <= out_x_next;
        out_z_reg <= out_z_next;
        out_h_reg <= out_h_next;
    end

    assign pose_x       = out_x_reg;
    assign pose_z       = out_z_reg;
    assign pose_heading = out_h_reg;

endmodule

`default_nettype wire

[sv/ddo_ctrl.sv]
`default_nettype none

module ddo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ddo_pkg::ddo_sts_t sts,
    output ddo_pkg::ddo_cmd_t cmd
);
    import ddo_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE = 4'd0;
    localparam logic [ST_W-1:0] S_DU   = 4'd1;
    localparam logic [ST_W-1:0] S_DTH  = 4'd2;
    localparam logic [ST_W-1:0] S_ANG  = 4'd3;
    localparam logic [ST_W-1:0] S_CORD = 4'd4;
    localparam logic [ST_W-1:0] S_MULX = 4'd5;
    localparam logic [ST_W-1:0] S_MULZ = 4'd6;
    localparam logic [ST_W-1:0] S_UPDZ = 4'd7;
    localparam logic [ST_W-1:0] S_DONE = 4'd8;

    logic [ST_W-1:0] state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    // The result register can take a new pose when empty or being read this cycle.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_DU;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DU;
                end
            end
            S_DU:
            begin
                cmd.mul_en      = 1'b1;
                cmd.mul_sel     = MUL_DU;
                cmd.cordic_init = 1'b1;
                state_next      = S_DTH;
            end
            S_DTH:
            begin
                cmd.du_load = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DTH;
                state_next  = S_ANG;
            end
            S_ANG:
            begin
                cmd.dth_load    = 1'b1;
                cmd.cordic_step = 1'b1;
                state_next      = S_CORD;
            end
            S_CORD:
            begin
                cmd.cordic_step = 1'b1;
                if (sts.cordic_last)
                begin
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X;
                state_next  = S_MULZ;
            end
            S_MULZ:
            begin
                cmd.upd_x   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Z;
                state_next  = S_UPDZ;
            end
            S_UPDZ:
            begin
                cmd.upd_z  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/differential_drive_odometry_core.sv]
`default_nettype none

// Channel | Direction | Payload                                   | Handshake
// --------+-----------+-------------------------------------------+----------------
// speed   | in        | left_speed, right_speed, restart_pose      | valid / ready
// pose    | out       | pose_x, pose_z, pose_heading               | valid / ready
//
// One transaction on speed produces exactly one transaction on pose. An item passes
// from acceptance to the result load through the two scale multiplies on the shared
// multiplier, 28 CORDIC iterations on a single shift-add rotator, and then the
// position products, saturating updates and result load. The core is back in idle
// in the cycle after the load; only then can the next speed transaction be accepted.
// Reset (rst_n low, asynchronous) zeroes the pose and empties the result register.
// A finished result waits in its register while the next item is accepted; the core
// stalls before the result load only if the previous result has not been taken.
module differential_drive_odometry_core (
    input  logic            clk,
    input  logic            rst_n,
    ddo_in_if.sink          speed,
    ddo_out_if.source       pose
);
    import ddo_pkg::*;

    ddo_cmd_t cmd;
    ddo_sts_t sts;

    // The controller sequences one item at a time through the shared datapath.
    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (speed.valid),
        .in_ready  (speed.ready),
        .out_valid (pose.valid),
        .out_ready (pose.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the pose, the CORDIC rotator, the multiplier and the
    // result register.
    ddo_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .left_speed   (speed.left_speed),
        .right_speed  (speed.right_speed),
        .restart_pose (speed.restart_pose),
        .pose_x       (pose.pose_x),
        .pose_z       (pose.pose_z),
        .pose_heading (pose.pose_heading)
    );

    // Only one item is in flight: after a transaction the input side closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (speed.valid && speed.ready) |=> !speed.ready)
        else $error("input accepted while an item is still in flight");

    // Loading a result makes it visible on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> pose.valid)
        else $error("result load did not raise pose valid");

    // A waiting result is never overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!pose.valid || pose.ready))
        else $error("result register overwritten while stalled");

    // Capture, multiply, rotate and result load belong to distinct steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_en, cmd.cordic_step, cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire
